>>> src/dwc_pkg.sv
// ----------------------------------------------------------------------------
// dwc_pkg: shared types and constants of the depthwise conv stream
// Formats, queue item layout, configuration codes and back-end states.
// ----------------------------------------------------------------------------
package dwc_pkg;

  localparam int unsigned MAX_TAPS    = 4;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned HIST_LEN    = MAX_TAPS - 1;
  localparam int unsigned FRAC_BITS   = 10;
  localparam int unsigned ACC_BITS    = 2 * SAMPLE_BITS + 4;
  localparam int unsigned SPROD_BITS  = SAMPLE_BITS + 18;

  typedef enum logic {
    KIND_LOAD,
    KIND_SAMPLE
  } kind_e;

  typedef enum logic [1:0] {
    CFG_TAP_COUNT = 2'd0,
    CFG_SILU      = 2'd1,
    CFG_PAD_SLOT  = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_ACC,
    ST_ROUND,
    ST_SMUL,
    ST_SRND,
    ST_DONE
  } back_state_e;

  typedef struct packed {
    logic [2:0] tap_count;
    logic       silu_enable;
    logic [3:0] pad_slot;
  } cfg_t;

  typedef struct packed {
    kind_e                                  kind;
    logic [7:0]                             channel;
    logic [2:0]                             slot;
    logic [SAMPLE_BITS-1:0]                 sample;
    logic [MAX_TAPS-1:0][SAMPLE_BITS-1:0]   taps;
    logic [SAMPLE_BITS-1:0]                 bias;
    logic                                   first;
    logic                                   keep;
  } item_t;

endpackage

>>> src/dwc_ram.sv
// ----------------------------------------------------------------------------
// dwc_ram: generic single-port ram
// One address per cycle, write or read, registered read data.
// ----------------------------------------------------------------------------
module dwc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

>>> src/dwc_front.sv
// ----------------------------------------------------------------------------
// dwc_front: input acceptance, classification and item queue
// Drops padding and out-of-range items, queues loads and samples.
// ----------------------------------------------------------------------------
module dwc_front #(
  parameter int unsigned CHANNELS = 256,
  parameter int unsigned SLOTS    = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dwc_pkg::cfg_t       cfg_i,
  input  logic                hold_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dwc_pkg::item_t      item_i,
  output logic                q_valid_o,
  output dwc_pkg::item_t      q_item_o,
  input  logic                q_pop_i
);
  import dwc_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       ch_ok, sl_ok, pad_hit, keep_item, push;

  assign ch_ok   = 32'(item_i.channel) < CHANNELS;
  assign sl_ok   = 32'(item_i.slot) < SLOTS;
  assign pad_hit = !cfg_i.pad_slot[3] && (cfg_i.pad_slot[2:0] == item_i.slot);

  always_comb begin
    unique case (item_i.kind)
      KIND_LOAD:   keep_item = ch_ok;
      KIND_SAMPLE: keep_item = ch_ok && sl_ok && !pad_hit;
      default:     keep_item = 1'b0;
    endcase
  end

  assign in_ready_o = (count_q != 2'd2) && !hold_i;
  assign push       = in_valid_i && in_ready_o && keep_item;
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + 2'(push) - 2'(q_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

>>> src/dwc_back.sv
// ----------------------------------------------------------------------------
// dwc_back: execution of queued items
// Coefficient and history rams, one multiplier shared by the taps, rounding, silu.
// ----------------------------------------------------------------------------
module dwc_back #(
  parameter int unsigned CHANNELS = 256,
  parameter int unsigned SLOTS    = 8,
  localparam int unsigned CW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int unsigned HDEPTH  = SLOTS * CHANNELS,
  localparam int unsigned HW      = (HDEPTH > 1) ? $clog2(HDEPTH) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dwc_pkg::cfg_t                     cfg_i,
  output logic                              clearing_o,
  input  logic                              q_valid_i,
  input  dwc_pkg::item_t                    q_item_i,
  output logic                              q_pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [dwc_pkg::SAMPLE_BITS-1:0]   filtered_value_o,
  output logic [7:0]                        out_channel_o,
  output logic [2:0]                        out_slot_o
);
  import dwc_pkg::*;

  localparam int unsigned SB = SAMPLE_BITS;

  back_state_e state_q, state_d;
  item_t       job_q;
  logic [HW-1:0] clr_q;
  logic [1:0]  idx_q;
  logic [MAX_TAPS-1:0][SB-1:0] taps_q;
  logic [MAX_TAPS-1:0][SB-1:0] win_q;
  logic signed [2*SB-1:0]     prod_q;
  logic signed [ACC_BITS-1:0] acc_q;
  logic signed [SB-1:0]       res_q;
  logic signed [SPROD_BITS-1:0] sprod_q;
  logic        out_valid_q;
  logic [SB-1:0] out_val_q;
  logic [7:0]  out_ch_q;
  logic [2:0]  out_sl_q;

  // ram ports
  logic                       tap_we, hist_we;
  logic [CW-1:0]              tap_addr;
  logic [HW-1:0]              hist_addr, head_haddr, job_haddr;
  logic [MAX_TAPS*SB-1:0]     tap_rdata;
  logic [SB-1:0]              bias_rdata;
  logic [HIST_LEN*SB-1:0]     hist_rdata, hist_wdata;

  logic [2:0]  k, k_minus1;
  logic [1:0]  off, win_idx;
  logic [HIST_LEN-1:0][SB-1:0] old_hist;
  logic        out_load;
  logic signed [ACC_BITS-1:0]   rnd_sum, rnd_shift;
  logic signed [SB-1:0]         rnd_sat, silu_sat;
  logic [16:0] mag, sig_raw, sig;
  logic signed [SPROD_BITS-1:0] s_sum, s_shift;

  dwc_ram #(.WIDTH(MAX_TAPS*SB), .DEPTH(CHANNELS)) u_tap_ram (
    .clk_i, .we_i(tap_we), .addr_i(tap_addr), .wdata_i(q_item_i.taps), .rdata_o(tap_rdata)
  );
  dwc_ram #(.WIDTH(SB), .DEPTH(CHANNELS)) u_bias_ram (
    .clk_i, .we_i(tap_we), .addr_i(tap_addr), .wdata_i(q_item_i.bias), .rdata_o(bias_rdata)
  );
  dwc_ram #(.WIDTH(HIST_LEN*SB), .DEPTH(HDEPTH)) u_hist_ram (
    .clk_i, .we_i(hist_we), .addr_i(hist_addr), .wdata_i(hist_wdata), .rdata_o(hist_rdata)
  );

  assign tap_addr   = CW'(q_item_i.channel);
  assign head_haddr = HW'(32'(q_item_i.slot) * CHANNELS + 32'(q_item_i.channel));
  assign job_haddr  = HW'(32'(job_q.slot) * CHANNELS + 32'(job_q.channel));

  // clamp tap count to 2..MAX_TAPS
  always_comb begin
    priority if (cfg_i.tap_count < 3'd2) k = 3'd2;
    else if (cfg_i.tap_count > 3'(MAX_TAPS)) k = 3'(MAX_TAPS);
    else k = cfg_i.tap_count;
  end
  assign k_minus1 = k - 3'd1;
  assign off      = 2'(3'(MAX_TAPS) - k);
  assign win_idx  = off + idx_q;

  // fresh sequence without history starts from zeros
  assign old_hist   = (job_q.first && !job_q.keep) ? '0 : hist_rdata;
  assign hist_wdata = (state_q == ST_CLEAR) ? '0 : {job_q.sample, old_hist[HIST_LEN-1:1]};

  // round half up and saturate
  assign rnd_sum   = acc_q + ACC_BITS'(1 << (FRAC_BITS - 1));
  assign rnd_shift = rnd_sum >>> FRAC_BITS;
  always_comb begin
    priority if (rnd_shift > ACC_BITS'(32767)) rnd_sat = 16'sh7fff;
    else if (rnd_shift < -ACC_BITS'(32768))    rnd_sat = 16'sh8000;
    else rnd_sat = SB'(rnd_shift);
  end

  // piecewise-linear sigmoid, unsigned q1.16
  assign mag = res_q[SB-1] ? 17'(17'd0 - {1'b1, res_q}) : {1'b0, res_q};
  always_comb begin
    priority if (mag < 17'd1024) sig_raw = 17'd32768 + {mag[12:0], 4'b0};
    else if (mag < 17'd2432)     sig_raw = 17'd40960 + {mag[13:0], 3'b0};
    else if (mag < 17'd5120)     sig_raw = 17'd55296 + {mag[15:0], 1'b0};
    else                         sig_raw = 17'd65536;
  end
  assign sig     = res_q[SB-1] ? 17'd65536 - sig_raw : sig_raw;
  assign s_sum   = sprod_q + SPROD_BITS'(32768);
  assign s_shift = s_sum >>> 16;
  always_comb begin
    priority if (s_shift > SPROD_BITS'(32767)) silu_sat = 16'sh7fff;
    else if (s_shift < -SPROD_BITS'(32768))    silu_sat = 16'sh8000;
    else silu_sat = SB'(s_shift);
  end

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d   = state_q;
    q_pop_o   = 1'b0;
    tap_we    = 1'b0;
    hist_we   = 1'b0;
    hist_addr = head_haddr;
    unique case (state_q)
      ST_CLEAR: begin
        hist_we   = 1'b1;
        hist_addr = clr_q;
        if (clr_q == HW'(HDEPTH - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_item_i.kind == KIND_LOAD) tap_we = 1'b1;
          else state_d = ST_READ;
        end
      end
      ST_READ: begin
        hist_we   = 1'b1;
        hist_addr = job_haddr;
        state_d   = ST_MUL;
      end
      ST_MUL:   state_d = ST_ACC;
      ST_ACC:   state_d = (3'(idx_q) == k_minus1) ? ST_ROUND : ST_MUL;
      ST_ROUND: state_d = cfg_i.silu_enable ? ST_SMUL : ST_DONE;
      ST_SMUL:  state_d = ST_SRND;
      ST_SRND:  state_d = ST_DONE;
      ST_DONE:  if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + HW'(1);
      if (state_q == ST_READ) idx_q <= '0;
      else if (state_q == ST_ACC) idx_q <= idx_q + 2'd1;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) job_q <= q_item_i;
    if (state_q == ST_READ) begin
      taps_q <= tap_rdata;
      win_q  <= {job_q.sample, old_hist};
      acc_q  <= ACC_BITS'($signed(bias_rdata)) <<< FRAC_BITS;
    end
    if (state_q == ST_MUL) prod_q <= $signed(taps_q[idx_q]) * $signed(win_q[win_idx]);
    if (state_q == ST_ACC) acc_q <= acc_q + ACC_BITS'(prod_q);
    if (state_q == ST_ROUND) res_q <= rnd_sat;
    if (state_q == ST_SMUL) sprod_q <= SPROD_BITS'(res_q) * SPROD_BITS'($signed({1'b0, sig}));
    if (state_q == ST_SRND) res_q <= silu_sat;
    if (out_load) begin
      out_val_q <= res_q;
      out_ch_q  <= job_q.channel;
      out_sl_q  <= job_q.slot;
    end
  end

  assign clearing_o       = (state_q == ST_CLEAR);
  assign out_valid_o      = out_valid_q;
  assign filtered_value_o = out_val_q;
  assign out_channel_o    = out_ch_q;
  assign out_slot_o       = out_sl_q;

`ifndef ASSERT_OFF
  a_done_is_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> job_q.kind == KIND_SAMPLE) else $error("result from a load item");
  a_tap_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL |-> 3'(idx_q) <= k_minus1) else $error("tap index past tap count");
  a_sample_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && q_item_i.kind == KIND_SAMPLE) |=> state_q == ST_READ)
    else $error("sample pop without history read");
`endif

endmodule

>>> src/causal_depthwise_conv_stream.sv
// ----------------------------------------------------------------------------
// causal_depthwise_conv_stream: per-channel causal fir with bias and silu
// Top level: configuration registers, front queue and execution back end.
// ----------------------------------------------------------------------------
// after reset the history ram (SLOTS*CHANNELS entries, 2048 by default) is
// swept to zero, one entry a cycle, and no input beat is taken until the sweep
// ends; configuration writes are taken at any time. a load beat only writes
// the tap and bias rams. a sample beat reads and writes back the history ram,
// then multiplies and accumulates the k taps (k the clamped tap count) in turn
// on one shared 16x16 multiplier, rounds, and with silu on multiplies by the
// sigmoid and rounds again. a two-entry queue decouples the input side, and a
// result register lets the next item start while a result still waits on the output
module causal_depthwise_conv_stream #(
  parameter int unsigned CHANNELS = 256,
  parameter int unsigned SLOTS    = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i,
  // input beat
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [7:0]  channel_i,
  input  logic [2:0]  slot_i,
  input  logic [15:0] sample_i,
  input  logic [15:0] tap_0_i,
  input  logic [15:0] tap_1_i,
  input  logic [15:0] tap_2_i,
  input  logic [15:0] tap_3_i,
  input  logic [15:0] bias_value_i,
  input  logic        first_sample_i,
  input  logic        keep_history_i,
  // result beat
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] filtered_value_o,
  output logic [7:0]  out_channel_o,
  output logic [2:0]  out_slot_o
);
  import dwc_pkg::*;

  cfg_t  cfg_q;
  item_t in_item, q_item;
  logic  q_valid, q_pop, clearing;

  // configuration registers, always writable
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tap_count   <= 3'd4;
      cfg_q.silu_enable <= 1'b0;
      cfg_q.pad_slot    <= 4'hf;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TAP_COUNT: cfg_q.tap_count   <= cfg_data_i[2:0];
        CFG_SILU:      cfg_q.silu_enable <= cfg_data_i[0];
        CFG_PAD_SLOT:  cfg_q.pad_slot    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pack the input beat, taps oldest first
  assign in_item.kind    = action_i ? KIND_SAMPLE : KIND_LOAD;
  assign in_item.channel = channel_i;
  assign in_item.slot    = slot_i;
  assign in_item.sample  = sample_i;
  assign in_item.taps    = {tap_3_i, tap_2_i, tap_1_i, tap_0_i};
  assign in_item.bias    = bias_value_i;
  assign in_item.first   = first_sample_i;
  assign in_item.keep    = keep_history_i;

  dwc_front #(.CHANNELS(CHANNELS), .SLOTS(SLOTS)) u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .hold_i(clearing),
    .in_valid_i, .in_ready_o, .item_i(in_item),
    .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop)
  );

  dwc_back #(.CHANNELS(CHANNELS), .SLOTS(SLOTS)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .clearing_o(clearing),
    .q_valid_i(q_valid), .q_item_i(q_item), .q_pop_o(q_pop),
    .out_valid_o, .out_ready_i, .filtered_value_o, .out_channel_o, .out_slot_o
  );

endmodule

>>> bench/dwc_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwc_stream_checker: result predictor and scoreboard for the conv stream
// Watches the configuration, input and result channels, keeps its own copy
// of taps, bias and history windows, and checks every result beat in order.
// ----------------------------------------------------------------------------
module dwc_stream_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        action_i,
  input  logic [7:0]  channel_i,
  input  logic [2:0]  slot_i,
  input  logic [15:0] sample_i,
  input  logic [15:0] tap_0_i,
  input  logic [15:0] tap_1_i,
  input  logic [15:0] tap_2_i,
  input  logic [15:0] tap_3_i,
  input  logic [15:0] bias_value_i,
  input  logic        first_sample_i,
  input  logic        keep_history_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [15:0] filtered_value_i,
  input  logic [7:0]  out_channel_i,
  input  logic [2:0]  out_slot_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);
  import dwc_pkg::*;

  typedef struct {
    logic [15:0] value;
    logic [7:0]  channel;
    logic [2:0]  slot;
  } conv_result_t;

  conv_result_t        expected_q[$];
  logic        [2:0]   tap_count_r;
  logic                silu_on_r;
  logic        [3:0]   pad_slot_r;
  logic signed [15:0]  coef_mem[256][4];
  logic signed [15:0]  bias_mem[256];
  logic signed [15:0]  window_mem[8][256][3];

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint silu_q(longint x);
    longint a;
    longint s;
    a = (x < 0) ? -x : x;
    if (a < 1024) s = 32768 + 16 * a;
    else if (a < 2432) s = 40960 + 8 * a;
    else if (a < 5120) s = 55296 + 2 * a;
    else s = 65536;
    if (x < 0) s = 65536 - s;
    return clip16((x * s + 32768) >>> 16);
  endfunction

  // filter one sample and shift it into the slot window
  function automatic logic [15:0] filter_sample(logic [7:0] ch, logic [2:0] sl,
                                                logic signed [15:0] x, logic fs,
                                                logic kh);
    longint acc;
    int     k;
    if (fs && !kh)
      for (int i = 0; i < 3; i++) window_mem[sl][ch][i] = '0;
    k = tap_count_r;
    if (k < 2) k = 2;
    if (k > 4) k = 4;
    acc = longint'(bias_mem[ch]) * 1024;
    for (int i = 0; i + 1 < k; i++)
      acc += longint'(coef_mem[ch][i]) * longint'(window_mem[sl][ch][3 - (k - 1) + i]);
    acc += longint'(coef_mem[ch][k-1]) * longint'(x);
    acc = clip16((acc + 512) >>> 10);
    if (silu_on_r) acc = silu_q(acc);
    window_mem[sl][ch][0] = window_mem[sl][ch][1];
    window_mem[sl][ch][1] = window_mem[sl][ch][2];
    window_mem[sl][ch][2] = x;
    return acc[15:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    conv_result_t r;
    conv_result_t e;
    if (!rst_ni) begin
      tap_count_r  = 3'd4;
      silu_on_r    = 1'b0;
      pad_slot_r   = 4'hF;
      fail_count_o = 0;
      checked_o    = 0;
      expected_q.delete();
      foreach (window_mem[s, c, i]) window_mem[s][c][i] = '0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_TAP_COUNT: tap_count_r = cfg_data_i[2:0];
          CFG_SILU:      silu_on_r   = cfg_data_i[0];
          CFG_PAD_SLOT:  pad_slot_r  = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (kind_e'(action_i) == KIND_LOAD) begin
          coef_mem[channel_i][0] = tap_0_i;
          coef_mem[channel_i][1] = tap_1_i;
          coef_mem[channel_i][2] = tap_2_i;
          coef_mem[channel_i][3] = tap_3_i;
          bias_mem[channel_i]    = bias_value_i;
        end else if (!(!pad_slot_r[3] && pad_slot_r[2:0] == slot_i)) begin
          r.value   = filter_sample(channel_i, slot_i, sample_i, first_sample_i,
                                    keep_history_i);
          r.channel = channel_i;
          r.slot    = slot_i;
          expected_q.push_back(r);
        end
      end
      if (out_valid_i && out_ready_i) begin
        checked_o++;
        if (expected_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected result beat value %h channel %0d slot %0d",
                   $time, filtered_value_i, out_channel_i, out_slot_i);
        end else begin
          e = expected_q.pop_front();
          if (filtered_value_i !== e.value) begin
            fail_count_o++;
            $display("%0t: filtered_value expected %h actual %h", $time, e.value,
                     filtered_value_i);
          end
          if (out_channel_i !== e.channel) begin
            fail_count_o++;
            $display("%0t: out_channel expected %0d actual %0d", $time, e.channel,
                     out_channel_i);
          end
          if (out_slot_i !== e.slot) begin
            fail_count_o++;
            $display("%0t: out_slot expected %0d actual %0d", $time, e.slot,
                     out_slot_i);
          end
        end
      end
    end
    pending_o = expected_q.size();
  end

endmodule

>>> bench/causal_depthwise_conv_stream_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// causal_depthwise_conv_stream_tb: stimulus and verdict for the conv stream
// Drives loads and samples through several register settings with random
// gaps and stalls; a checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module causal_depthwise_conv_stream_tb;
  import dwc_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [3:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        action_i = 1'b0;
  logic [7:0]  channel_i = '0;
  logic [2:0]  slot_i = '0;
  logic [15:0] sample_i = '0;
  logic [15:0] tap_0_i = '0;
  logic [15:0] tap_1_i = '0;
  logic [15:0] tap_2_i = '0;
  logic [15:0] tap_3_i = '0;
  logic [15:0] bias_value_i = '0;
  logic        first_sample_i = 1'b0;
  logic        keep_history_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] filtered_value_o;
  logic [7:0]  out_channel_o;
  logic [2:0]  out_slot_o;

  int fail_count;
  int pending;
  int checked;

  // loaded channels, so no sample ever hits an unloaded one
  logic [7:0] loaded_q[$];
  bit         loaded_map[256];
  bit         quiet;        // no gaps or stalls in this stretch
  bit         hold_req;     // ask the receiver for one long hold-off
  int         beats_sent;

  // register settings per phase: tap count, silu, pad slot; the out-of-range
  // tap counts and the negative pad values that never match are in here too
  logic [3:0] phase_taps[8] = '{4'd4, 4'd2, 4'd3, 4'd4, 4'd0, 4'd7, 4'd1, 4'd5};
  logic [3:0] phase_silu[8] = '{4'd0, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1};
  logic [3:0] phase_pad[8]  = '{4'hF, 4'd0, 4'd7, 4'd3, 4'h8, 4'hF, 4'd5, 4'd2};

  causal_depthwise_conv_stream dut (.*);

  dwc_stream_checker checker_i (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i,
    .cfg_data_i, .in_valid_i, .in_ready_i(in_ready_o), .action_i, .channel_i,
    .slot_i, .sample_i, .tap_0_i, .tap_1_i, .tap_2_i, .tap_3_i, .bias_value_i,
    .first_sample_i, .keep_history_i, .out_valid_i(out_valid_o), .out_ready_i,
    .filtered_value_i(filtered_value_o), .out_channel_i(out_channel_o),
    .out_slot_i(out_slot_o), .fail_count_o(fail_count), .pending_o(pending),
    .checked_o(checked)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // hard stop well past the slowest legal run
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  // operand mix: extremes, small values near the silu knees, full range
  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2, 3, 4: return 16'($signed($urandom_range(0, 6144)) - 3072);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [3:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // one input beat; valid stays up across back-to-back beats
  task automatic send_beat(input kind_e act, input logic [7:0] ch, input logic [2:0] sl,
                           input logic [15:0] x, input logic [15:0] t0,
                           input logic [15:0] t1, input logic [15:0] t2,
                           input logic [15:0] t3, input logic [15:0] b,
                           input logic fs, input logic kh);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    action_i       <= act;
    channel_i      <= ch;
    slot_i         <= sl;
    sample_i       <= x;
    tap_0_i        <= t0;
    tap_1_i        <= t1;
    tap_2_i        <= t2;
    tap_3_i        <= t3;
    bias_value_i   <= b;
    first_sample_i <= fs;
    keep_history_i <= kh;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    beats_sent++;
  endtask

  task automatic load_channel(input logic [7:0] ch, input logic [15:0] t0,
                              input logic [15:0] t1, input logic [15:0] t2,
                              input logic [15:0] t3, input logic [15:0] b);
    // slot, sample and sequence flags are don't-care on a load
    send_beat(KIND_LOAD, ch, 3'($urandom), 16'($urandom), t0, t1, t2, t3, b,
              1'($urandom), 1'($urandom));
    if (!loaded_map[ch]) begin
      loaded_map[ch] = 1'b1;
      loaded_q.push_back(ch);
    end
  endtask

  task automatic push_sample(input logic [7:0] ch, input logic [2:0] sl,
                             input logic [15:0] x, input logic fs, input logic kh);
    // tap and bias fields are don't-care on a sample
    send_beat(KIND_SAMPLE, ch, sl, x, 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom), fs, kh);
  endtask

  // drain: all results back, then room for loads and padded beats in flight
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (60) @(negedge clk_i);
  endtask

  // result side: random stall per beat, plus one long hold-off on request
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (400) @(negedge clk_i);
      end
      stall = quiet ? 0 : $urandom_range(0, 16);
      repeat (stall) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  initial begin
    int         r;
    logic [7:0] ch;
    quiet      = 1'b0;
    hold_req   = 1'b0;
    beats_sent = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_TAP_COUNT, phase_taps[ph]);
      write_reg(CFG_SILU, phase_silu[ph]);
      write_reg(CFG_PAD_SLOT, phase_pad[ph]);

      if (ph == 0) begin
        // directed: unit taps, extreme taps and bias, alternating bit patterns
        load_channel(8'd0, 16'd1024, 16'd1024, 16'd1024, 16'd1024, 16'd0);
        load_channel(8'd255, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        load_channel(8'd170, 16'h5555, 16'hAAAA, 16'h0400, 16'hFC00, 16'h7FFF);
        push_sample(8'd0, 3'd0, 16'h7FFF, 1'b1, 1'b0);
        push_sample(8'd0, 3'd0, 16'h8000, 1'b0, 1'b0);
        push_sample(8'd0, 3'd0, 16'h0001, 1'b0, 1'b1);
        push_sample(8'd0, 3'd0, 16'h0200, 1'b0, 1'b0);
        // sequence restart keeping the stored window, then one clearing it
        push_sample(8'd0, 3'd0, 16'h0400, 1'b1, 1'b1);
        push_sample(8'd0, 3'd0, 16'hFC00, 1'b1, 1'b0);
        push_sample(8'd0, 3'd7, 16'h0001, 1'b1, 1'b1);
        push_sample(8'd255, 3'd7, 16'h7FFF, 1'b1, 1'b0);
        push_sample(8'd255, 3'd7, 16'h7FFF, 1'b0, 1'b0);
        push_sample(8'd255, 3'd5, 16'h8000, 1'b0, 1'b0);
        push_sample(8'd170, 3'd2, 16'h5555, 1'b1, 1'b0);
        push_sample(8'd170, 3'd2, 16'hAAAA, 1'b0, 1'b0);
        // reload a channel mid-sequence
        load_channel(8'd0, 16'hFFFF, 16'h0001, 16'h0000, 16'h0800, 16'h0200);
        push_sample(8'd0, 3'd0, 16'h0400, 1'b0, 1'b0);
        push_sample(8'd0, 3'd7, 16'h1400, 1'b0, 1'b0);
      end
      if (ph == 1) hold_req = 1'b1;   // block fills up behind the stalled output
      quiet = (ph == 3);

      for (int n = 0; n < 200; n++) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          // loads mostly on a small set of channels, so reloads hit live windows
          ch = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
          load_channel(ch, pick_value(), pick_value(), pick_value(), pick_value(),
                       pick_value());
        end else if (r < 18) begin
          // noise: sample with arbitrary sequence flags on any slot
          push_sample(loaded_q[$urandom_range(0, loaded_q.size() - 1)], 3'($urandom),
                      16'($urandom), 1'($urandom), 1'($urandom));
        end else begin
          push_sample(loaded_q[$urandom_range(0, loaded_q.size() - 1)], 3'($urandom),
                      pick_value(), $urandom_range(0, 9) == 0, 1'($urandom));
        end
      end
      wait_drained();
    end

    $display("run covered %0d input beats over 8 register settings, %0d results checked",
             beats_sent, checked);
    $display("tap counts below, inside and above 2..4, silu on and off, pad slots none, in range and negative");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
